### rtl/core/source_freshness_watchdog_defines.svh
// Assertion macros for the source freshness watchdog RTL.
`ifndef SOURCE_FRESHNESS_WATCHDOG_DEFINES_SVH
`define SOURCE_FRESHNESS_WATCHDOG_DEFINES_SVH

`ifndef ASSERT_OFF

`define SFW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define SFW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SFW_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define SFW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/sfw_pkg.sv
`default_nettype none

package sfw_pkg;

    localparam int NUM_SOURCES   = 4;
    localparam int SRC_W         = 2;
    localparam int CNT_W         = 32;
    localparam int TIME_W        = 64;
    localparam int WKC_W         = 16;
    localparam int RUN_W         = 16;
    localparam int TIMEOUT_W     = 16;
    localparam int LIMIT_W       = 36;
    localparam int NS_PER_MS     = 1000000;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W        = $clog2(QDEPTH + 1);
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(100);
    localparam logic [RUN_W-1:0]     RUN_MAX       = '1;

    typedef enum logic [0:0] {
        REG_STALE_TIMEOUT = 1'b0
    } t_reg_index;

    typedef struct packed {
        logic [SRC_W-1:0]  source_id;
        logic              was_read;
        logic              is_configured;
        logic              link_running;
        logic              data_ok;
        logic [WKC_W-1:0]  wkc_actual;
        logic [WKC_W-1:0]  wkc_expected;
        logic [CNT_W-1:0]  update_count;
        logic [TIME_W-1:0] now_ns;
    } t_in_item;

    typedef struct packed {
        logic              input_valid;
        logic              fresh;
        logic [TIME_W-1:0] last_fresh_ns;
        logic [TIME_W-1:0] stale_ns;
        logic              comm_valid;
        logic [RUN_W-1:0]  invalid_run;
    } t_out_item;

    typedef struct packed {
        logic              input_valid;
        logic              fresh;
        logic              was_read;
        logic [TIME_W-1:0] last_ns;
        logic [TIME_W-1:0] now_ns;
        logic [RUN_W-1:0]  invalid_run;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

### rtl/core/sfw_in_if.sv
`default_nettype none

interface sfw_in_if;
    import sfw_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/sfw_out_if.sv
`default_nettype none

interface sfw_out_if;
    import sfw_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/source_freshness_watchdog.sv
// Freshness watchdog for up to four fieldbus data sources. Each item names a source and carries
// its status flags, working counters, update count and a nanosecond timestamp; one result item
// comes back for each, in order, with the combined validity, whether the update was fresh, the
// stored fresh time, the stale time, the communication verdict and the invalid run count. The
// block takes one item per clock while its queue is not full: the per-source records are read
// and updated in the accept cycle, a two-entry queue feeds the stale-time subtract and timeout
// compare, and the result sits in an output register, so an accepted item passes through the
// queue and the output register before its result is presented. The timeout register is written
// over APB at byte address 0 and takes effect once r_limit has been recomputed from it.
`default_nettype none

module source_freshness_watchdog (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    sfw_in_if.sink                          i_in,
    sfw_out_if.source                       o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [sfw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [sfw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sfw_pkg::*;

    logic [TIMEOUT_W-1:0] r_timeout;
    logic [LIMIT_W-1:0]   r_limit;
    logic                 push;
    logic                 pop;
    t_rec                 push_rec;
    t_rec                 head;
    t_q_status            q_status;
    logic                 reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (t_reg_index'(paddr[2]) == REG_STALE_TIMEOUT);
    assign prdata  = reg_sel ? APB_DATA_W'(r_timeout) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
            r_limit   <= LIMIT_W'(TIMEOUT_RESET) * LIMIT_W'(NS_PER_MS);
        end else begin
            if (psel && penable && pwrite && reg_sel) begin
                r_timeout <= pwdata[TIMEOUT_W-1:0];
            end
            r_limit <= LIMIT_W'(r_timeout) * LIMIT_W'(NS_PER_MS);
        end
    end

    sfw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_rec (push_rec)
    );

    sfw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_rec (push_rec),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    sfw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .i_limit    (r_limit),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

### rtl/core/sfw_front.sv
`default_nettype none

module sfw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sfw_in_if.sink            i_in,
    input  sfw_pkg::t_q_status i_q_status,
    output logic              o_push,
    output sfw_pkg::t_rec     o_push_rec
);
    import sfw_pkg::*;

    logic                r_seen  [NUM_SOURCES];
    logic [CNT_W-1:0]    r_count [NUM_SOURCES];
    logic [TIME_W-1:0]   r_time  [NUM_SOURCES];
    logic [RUN_W-1:0]    r_run   [NUM_SOURCES];

    logic                accept;
    logic                in_range;
    logic                valid_c;
    logic                fresh_c;
    logic [SRC_W-1:0]    idx;
    logic [RUN_W-1:0]    n_run;
    logic [TIME_W-1:0]   n_last;

    assign i_in.ready = !i_q_status.full;
    assign accept     = i_in.valid && i_in.ready;
    assign idx        = i_in.data.source_id;

    always_comb begin
        in_range = (int'(i_in.data.source_id) < NUM_SOURCES);
        valid_c  = i_in.data.was_read && i_in.data.is_configured &&
                   i_in.data.link_running && i_in.data.data_ok &&
                   (i_in.data.wkc_actual >= i_in.data.wkc_expected);
        fresh_c  = valid_c && in_range &&
                   (!r_seen[idx] || (i_in.data.update_count != r_count[idx]));
        if (valid_c) begin
            n_run = '0;
        end else if (r_run[idx] == RUN_MAX) begin
            n_run = r_run[idx];
        end else begin
            n_run = r_run[idx] + RUN_W'(1);
        end
        n_last = fresh_c ? i_in.data.now_ns : r_time[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SOURCES; i++) begin
                r_seen[i]  <= 1'b0;
                r_count[i] <= '0;
                r_time[i]  <= '0;
                r_run[i]   <= '0;
            end
        end else if (accept && in_range) begin
            r_run[idx] <= n_run;
            if (fresh_c) begin
                r_seen[idx]  <= 1'b1;
                r_count[idx] <= i_in.data.update_count;
                r_time[idx]  <= i_in.data.now_ns;
            end
        end
    end

    always_comb begin
        o_push                 = accept;
        o_push_rec.input_valid = valid_c;
        o_push_rec.fresh       = fresh_c;
        o_push_rec.was_read    = i_in.data.was_read && in_range;
        o_push_rec.last_ns     = in_range ? n_last : '0;
        o_push_rec.now_ns      = i_in.data.now_ns;
        o_push_rec.invalid_run = in_range ? n_run : '0;
    end

endmodule

`default_nettype wire

### rtl/core/sfw_queue.sv
`default_nettype none
`include "source_freshness_watchdog_defines.svh"

module sfw_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sfw_pkg::t_rec       i_push_rec,
    input  logic                i_pop,
    output sfw_pkg::t_rec       o_head,
    output sfw_pkg::t_q_status  o_status
);
    import sfw_pkg::*;

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `SFW_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push && !i_pop, !o_status.full)
    `SFW_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_status.empty)
    `SFW_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, r_count != '0)
    `SFW_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QDEPTH))

endmodule

`default_nettype wire

### rtl/core/sfw_back.sv
`default_nettype none

module sfw_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sfw_pkg::t_rec                i_head,
    input  sfw_pkg::t_q_status           i_q_status,
    input  logic [sfw_pkg::LIMIT_W-1:0]  i_limit,
    output logic                         o_pop,
    sfw_out_if.source                    o_out
);
    import sfw_pkg::*;

    logic              r_valid;
    t_out_item         r_data;
    t_out_item         n_data;
    logic [TIME_W-1:0] stale;

    assign o_pop = !i_q_status.empty && (!r_valid || o_out.ready);

    always_comb begin
        if ((i_head.last_ns != '0) && (i_head.now_ns >= i_head.last_ns)) begin
            stale = i_head.now_ns - i_head.last_ns;
        end else begin
            stale = '0;
        end
        n_data.input_valid   = i_head.input_valid;
        n_data.fresh         = i_head.fresh;
        n_data.last_fresh_ns = i_head.last_ns;
        n_data.stale_ns      = stale;
        n_data.comm_valid    = i_head.was_read && (i_head.last_ns != '0) &&
                               (stale <= TIME_W'(i_limit));
        n_data.invalid_run   = i_head.invalid_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    assign o_out.valid = r_valid;
    assign o_out.data  = r_data;

endmodule

`default_nettype wire

### dv/tb_source_freshness_watchdog.sv
`default_nettype none

module tb_source_freshness_watchdog;
    import sfw_pkg::*;

    localparam int KEEP = -1;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_ITEMS = 150;
    localparam logic [TIME_W-1:0] T_MAX = '1;
    localparam logic [TIME_W-1:0] T_HALF = 64'h8000_0000_0000_0000;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct {
        bit        known;
        t_out_item res;
    } t_row_expect;

    typedef struct {
        int        tmo;
        t_in_item  item;
        bit        known;
        t_out_item res;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    sfw_in_if  in_if();
    sfw_out_if out_if();

    source_freshness_watchdog dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    logic                 src_seen     [NUM_SOURCES];
    logic [CNT_W-1:0]     src_count    [NUM_SOURCES];
    logic [TIME_W-1:0]    src_fresh_ns [NUM_SOURCES];
    logic [RUN_W-1:0]     src_bad_run  [NUM_SOURCES];
    logic [TIMEOUT_W-1:0] timeout_mirror;

    logic [TIME_W-1:0] t_base;
    logic [CNT_W-1:0]  cnt_base [NUM_SOURCES];

    t_row_expect known_q[$];
    t_out_item   status_q[$];
    t_stim_row   dir_rows[$];

    int n_sent = 0;
    int n_recv = 0;
    int n_errors = 0;
    int quiet_cycles = 0;

    function automatic void log_failure(string msg);
        n_errors++;
        if (n_errors <= 10) begin
            $display("%s", msg);
        end
    endfunction

    function automatic t_out_item predict_status(t_in_item it);
        t_out_item r;
        logic ok;
        logic [TIME_W-1:0] last;
        logic [TIME_W-1:0] stale;
        logic [TIME_W-1:0] lim;
        int s;
        ok = it.was_read && it.is_configured && it.link_running && it.data_ok &&
             (it.wkc_actual >= it.wkc_expected);
        r = '0;
        r.input_valid = ok;
        s = int'(it.source_id);
        if (s >= NUM_SOURCES) begin
            return r;
        end
        if (ok) begin
            src_bad_run[s] = '0;
        end else if (src_bad_run[s] != RUN_MAX) begin
            src_bad_run[s] = src_bad_run[s] + 1'b1;
        end
        if (ok && (!src_seen[s] || it.update_count != src_count[s])) begin
            src_seen[s] = 1'b1;
            src_count[s] = it.update_count;
            src_fresh_ns[s] = it.now_ns;
            r.fresh = 1'b1;
        end
        last = src_fresh_ns[s];
        stale = '0;
        if (last != 0 && it.now_ns >= last) begin
            stale = it.now_ns - last;
        end
        lim = TIME_W'(timeout_mirror) * TIME_W'(NS_PER_MS);
        r.last_fresh_ns = last;
        r.stale_ns = stale;
        r.comm_valid = it.was_read && last != 0 && stale <= lim;
        r.invalid_run = src_bad_run[s];
        return r;
    endfunction

    function automatic t_in_item inp(int src, bit rd, bit cfg, bit lnk, bit dok, int wact,
                                     int wexp, logic [CNT_W-1:0] cnt, logic [TIME_W-1:0] now);
        t_in_item it;
        it.source_id = SRC_W'(src);
        it.was_read = rd;
        it.is_configured = cfg;
        it.link_running = lnk;
        it.data_ok = dok;
        it.wkc_actual = WKC_W'(wact);
        it.wkc_expected = WKC_W'(wexp);
        it.update_count = cnt;
        it.now_ns = now;
        return it;
    endfunction

    function automatic t_out_item res(bit iv, bit fr, logic [TIME_W-1:0] last,
                                      logic [TIME_W-1:0] stale, bit comm, int run);
        t_out_item r;
        r.input_valid = iv;
        r.fresh = fr;
        r.last_fresh_ns = last;
        r.stale_ns = stale;
        r.comm_valid = comm;
        r.invalid_run = RUN_W'(run);
        return r;
    endfunction

    function automatic t_stim_row row(int tmo, t_in_item it, bit known, t_out_item r);
        t_stim_row x;
        x.tmo = tmo;
        x.item = it;
        x.known = known;
        x.res = r;
        return x;
    endfunction

    // Mostly well-formed traffic on a rising time base, with time steps scaled to the
    // current timeout so that the stale time crosses the limit in both directions.
    function automatic t_in_item next_random_item();
        t_in_item it;
        int kind;
        int s;
        int wexp;
        logic [TIME_W-1:0] lim;
        logic [TIME_W-1:0] step;
        kind = $urandom_range(0, 9);
        s = $urandom_range(0, NUM_SOURCES - 1);
        lim = TIME_W'(timeout_mirror) * TIME_W'(NS_PER_MS);
        wexp = $urandom_range(0, 65535);
        it = inp(s, 1, 1, 1, 1, $urandom_range(65535, wexp), wexp, cnt_base[s], t_base);
        if (kind <= 6) begin
            if ($urandom_range(0, 9) < 4) begin
                cnt_base[s] = ($urandom_range(0, 15) == 0) ? $urandom : cnt_base[s] + 1'b1;
                it.update_count = cnt_base[s];
            end
            case ($urandom_range(0, 3))
                0: step = '0;
                1: step = TIME_W'($urandom_range(0, 1000));
                2: step = {$urandom, $urandom} % (lim + 2);
                default: step = {$urandom, $urandom} % (2 * lim + 3);
            endcase
            t_base = t_base + step;
            it.now_ns = t_base;
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 4))
                    0: it.was_read = 1'b0;
                    1: it.is_configured = 1'b0;
                    2: it.link_running = 1'b0;
                    3: it.data_ok = 1'b0;
                    default: it.wkc_actual = (wexp == 0) ? '0 : WKC_W'(wexp - 1);
                endcase
            end
        end else if (kind == 7) begin
            it.was_read = $urandom_range(0, 1);
            it.is_configured = $urandom_range(0, 1);
            it.link_running = $urandom_range(0, 1);
            it.data_ok = $urandom_range(0, 1);
            it.wkc_actual = WKC_W'($urandom);
            it.wkc_expected = WKC_W'($urandom);
            it.now_ns = t_base - TIME_W'($urandom_range(0, 5000));
        end else if (kind == 8) begin
            it = inp(s, $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                     $urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom, {$urandom, $urandom});
        end else begin
            it.update_count = $urandom;
            it.now_ns = '0;
        end
        return it;
    endfunction

    task automatic send_item(input t_in_item it, input bit known, input t_out_item r);
        t_row_expect tag;
        tag.known = known;
        tag.res = r;
        known_q.push_back(tag);
        in_if.data <= it;
        in_if.valid <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        n_sent++;
    endtask

    task automatic idle_gap();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (n_recv < n_sent) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic apb_access(input t_reg_index idx, input bit wr, input logic [31:0] wval,
                              output logic [31:0] rval);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= APB_ADDR_W'(4 * int'(idx));
        pwdata <= wval;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rval = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_timeout_reg(input logic [TIMEOUT_W-1:0] want);
        logic [31:0] got;
        apb_access(REG_STALE_TIMEOUT, 1'b0, '0, got);
        if (got !== 32'(want)) begin
            log_failure($sformatf("timeout register read: expected %0d, got %0h", want, got));
        end
    endtask

    task automatic set_timeout(input int ms);
        logic [31:0] unused;
        apb_access(REG_STALE_TIMEOUT, 1'b1, {16'($urandom), 16'(ms)}, unused);
        timeout_mirror = TIMEOUT_W'(ms);
        check_timeout_reg(timeout_mirror);
    endtask

    task automatic send_stream(input int n);
        int left;
        int burst;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && left > 0) begin
                send_item(next_random_item(), 1'b0, '0);
                burst--;
                left--;
            end
            idle_gap();
        end
    endtask

    initial begin
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            left--;
            tick++;
            case (mode)
                0: out_if.ready <= 1'b1;
                1: out_if.ready <= $urandom_range(0, 1);
                2: out_if.ready <= (tick % 11) >= 3;
                default: out_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_row_expect tag;
        t_out_item want;
        t_out_item got;
        if (i_rst_n) begin
            quiet_cycles++;
            if (in_if.valid && in_if.ready) begin
                quiet_cycles = 0;
                want = predict_status(in_if.data);
                if (known_q.size() != 0) begin
                    tag = known_q.pop_front();
                    if (tag.known) begin
                        want = tag.res;
                    end
                end
                status_q.push_back(want);
            end
            if (out_if.valid && out_if.ready) begin
                quiet_cycles = 0;
                n_recv++;
                got = out_if.data;
                if (status_q.size() == 0) begin
                    log_failure($sformatf("result %0d arrived with nothing expected", n_recv));
                end else begin
                    want = status_q.pop_front();
                    if (got.input_valid !== want.input_valid || got.fresh !== want.fresh ||
                        got.last_fresh_ns !== want.last_fresh_ns ||
                        got.stale_ns !== want.stale_ns ||
                        got.comm_valid !== want.comm_valid ||
                        got.invalid_run !== want.invalid_run) begin
                        log_failure($sformatf({"result %0d: expected iv=%0b fr=%0b last=%0h ",
                            "stale=%0h comm=%0b run=%0d, got iv=%0b fr=%0b last=%0h stale=%0h ",
                            "comm=%0b run=%0d"}, n_recv, want.input_valid, want.fresh,
                            want.last_fresh_ns, want.stale_ns, want.comm_valid,
                            want.invalid_run, got.input_valid, got.fresh, got.last_fresh_ns,
                            got.stale_ns, got.comm_valid, got.invalid_run));
                    end
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("source_freshness_watchdog: mismatch");
        $finish;
    end

    initial begin
        int timeouts[6];
        t_stim_row r;
        i_rst_n <= 1'b0;
        in_if.valid <= 1'b0;
        in_if.data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (int s = 0; s < NUM_SOURCES; s++) begin
            src_seen[s] = 1'b0;
            src_count[s] = '0;
            src_fresh_ns[s] = '0;
            src_bad_run[s] = '0;
            cnt_base[s] = $urandom;
        end
        timeout_mirror = TIMEOUT_RESET;
        t_base = TIME_W'($urandom) + 1;

        dir_rows.push_back(row(KEEP, inp(0, 1, 1, 1, 1, 0, 0, 0, 0), 1, res(1, 1, 0, 0, 0, 0)));
        dir_rows.push_back(row(KEEP, inp(0, 1, 1, 1, 1, 0, 0, 0, 1000), 1,
                               res(1, 0, 0, 0, 0, 0)));
        dir_rows.push_back(row(KEEP, inp(0, 1, 1, 1, 1, 0, 0, 1, 1000), 1,
                               res(1, 1, 1000, 0, 1, 0)));
        dir_rows.push_back(row(KEEP, inp(0, 1, 1, 1, 1, 3, 2, 1, 100_001_000), 1,
                               res(1, 0, 1000, 100_000_000, 1, 0)));
        dir_rows.push_back(row(KEEP, inp(0, 1, 1, 1, 1, 3, 2, 1, 100_001_001), 1,
                               res(1, 0, 1000, 100_000_001, 0, 0)));
        dir_rows.push_back(row(KEEP, inp(0, 0, 1, 1, 1, 0, 0, 1, 2000), 1,
                               res(0, 0, 1000, 1000, 0, 1)));
        dir_rows.push_back(row(KEEP, inp(0, 1, 0, 1, 1, 0, 0, 1, 500), 1,
                               res(0, 0, 1000, 0, 1, 2)));
        dir_rows.push_back(row(KEEP, inp(0, 1, 1, 0, 1, 0, 0, 2, 3000), 0, '0));
        dir_rows.push_back(row(KEEP, inp(0, 1, 1, 1, 0, 0, 0, 2, 4000), 0, '0));
        dir_rows.push_back(row(KEEP, inp(0, 1, 1, 1, 1, 5, 6, 2, 5000), 0, '0));
        dir_rows.push_back(row(KEEP, inp(0, 1, 1, 1, 1, 0, 0, 7, 0), 1, res(1, 1, 0, 0, 0, 0)));
        dir_rows.push_back(row(KEEP, inp(0, 1, 1, 1, 1, 65535, 65535, CNT_MAX, T_MAX), 1,
                               res(1, 1, T_MAX, 0, 1, 0)));
        dir_rows.push_back(row(KEEP, inp(1, 1, 1, 1, 1, 65535, 0, 0, T_MAX), 1,
                               res(1, 1, T_MAX, 0, 1, 0)));
        dir_rows.push_back(row(KEEP, inp(2, 1, 1, 1, 1, 0, 65535, 0, T_HALF), 1,
                               res(0, 0, 0, 0, 0, 1)));
        dir_rows.push_back(row(KEEP, inp(3, 1, 1, 1, 1, 9, 9, CNT_MAX, 1), 1,
                               res(1, 1, 1, 0, 1, 0)));
        dir_rows.push_back(row(KEEP, inp(3, 1, 1, 1, 1, 9, 9, 0, T_MAX), 0, '0));
        dir_rows.push_back(row(KEEP, inp(2, 1, 1, 1, 1, 1, 0, 32'hA5A5_A5A5, T_HALF), 0, '0));
        dir_rows.push_back(row(KEEP, inp(2, 1, 1, 1, 1, 1, 0, 32'hA5A5_A5A5, T_HALF + 12345),
                               0, '0));
        dir_rows.push_back(row(KEEP, inp(1, 1, 1, 1, 1, 0, 0, 0, 5), 0, '0));
        dir_rows.push_back(row(0, inp(3, 1, 1, 1, 1, 0, 0, 0, T_MAX), 0, '0));
        dir_rows.push_back(row(KEEP, inp(2, 1, 1, 1, 1, 0, 0, 32'hA5A5_A5A5, T_HALF + 1),
                               0, '0));
        dir_rows.push_back(row(65535, inp(2, 1, 1, 1, 1, 0, 0, 32'hA5A5_A5A5,
                               T_HALF + 64'd65_535_000_000), 0, '0));
        dir_rows.push_back(row(KEEP, inp(2, 1, 1, 1, 1, 0, 0, 32'hA5A5_A5A5,
                               T_HALF + 64'd65_535_000_001), 0, '0));
        dir_rows.push_back(row(100, inp(0, 0, 0, 0, 0, 65535, 65535, CNT_MAX, 0), 0, '0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        check_timeout_reg(TIMEOUT_RESET);

        foreach (dir_rows[k]) begin
            r = dir_rows[k];
            if (r.tmo != KEEP) begin
                wait_idle();
                set_timeout(r.tmo);
            end
            send_item(r.item, r.known, r.res);
            idle_gap();
        end

        timeouts = '{1, 0, 65535, $urandom_range(0, 65535), 2, 100};
        foreach (timeouts[p]) begin
            wait_idle();
            set_timeout(timeouts[p]);
            send_stream(PHASE_ITEMS);
        end

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (status_q.size() != 0) begin
            log_failure($sformatf("%0d expected results never arrived", status_q.size()));
        end
        if (n_errors == 0) begin
            $display("source_freshness_watchdog: match");
        end else begin
            $display("source_freshness_watchdog: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+rtl/core
rtl/core/sfw_pkg.sv
rtl/core/sfw_in_if.sv
rtl/core/sfw_out_if.sv
rtl/core/sfw_front.sv
rtl/core/sfw_queue.sv
rtl/core/sfw_back.sv
rtl/core/source_freshness_watchdog.sv
dv/tb_source_freshness_watchdog.sv
